// File: hdl/hsv2rgb_pkg.sv
// Shared types, constants and fixed-point helpers for the HSV to RGB converter.
package hsv2rgb_pkg;

    // Field widths
    localparam int unsigned HueWidth  = 15;
    localparam int unsigned ChanWidth = 8;
    localparam int unsigned FracWidth = 12;

    // Hue scale: 64 units per degree
    localparam int unsigned HueFullTurn = 23040;
    localparam int unsigned HueSector   = 3840;
    localparam int unsigned UnitOne     = 255;

    // Reciprocals: floor(y / 15) = (y * 4370) >> 16 for y < 3825,
    // floor(z / 255) = (z * 32897) >> 23 for z < 65536
    localparam int unsigned Recip15  = 4370;
    localparam int unsigned Recip255 = 32897;

    typedef enum logic [2:0] {
        SECTOR_0 = 3'd0,
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5
    } sector_t;

    typedef struct packed {
        logic [ChanWidth-1:0] v;
        logic [ChanWidth-1:0] p;
        logic [ChanWidth-1:0] q;
        logic [ChanWidth-1:0] t;
    } terms_t;

    typedef struct packed {
        logic [ChanWidth-1:0] r;
        logic [ChanWidth-1:0] g;
        logic [ChanWidth-1:0] b;
    } rgb_t;

    // Truncating divide of a saturation-times-fraction product by 3840 (= 256 * 15)
    function automatic logic [ChanWidth-1:0] div_sector(input logic [19:0] x);
        logic [24:0] prod;
        prod = 25'(x[19:8]) * 25'(Recip15);
        return prod[23:16];
    endfunction

    // Truncating divide of an 8x8 product by 255
    function automatic logic [ChanWidth-1:0] div_unit(input logic [15:0] z);
        logic [31:0] prod;
        prod = 32'(z) * 32'(Recip255);
        return prod[30:23];
    endfunction

endpackage

// File: hdl/hsv2rgb_pix_in_if.sv
// Input channel: one HSV pixel word per handshake.
interface hsv2rgb_pix_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [hsv2rgb_pkg::HueWidth-1:0]       hue;
    logic [hsv2rgb_pkg::ChanWidth-1:0]      saturation;
    logic [hsv2rgb_pkg::ChanWidth-1:0]      brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

// File: hdl/hsv2rgb_pix_out_if.sv
// Output channel: one RGB pixel word per handshake.
interface hsv2rgb_pix_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [hsv2rgb_pkg::ChanWidth-1:0]      red;
    logic [hsv2rgb_pkg::ChanWidth-1:0]      green;
    logic [hsv2rgb_pkg::ChanWidth-1:0]      blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: hdl/hsv2rgb_route.sv
// Sector routing of value, p, q and t onto the red, green and blue channels.
module hsv2rgb_route
(
    input  hsv2rgb_pkg::sector_t sector,
    input  hsv2rgb_pkg::terms_t  terms,
    output hsv2rgb_pkg::rgb_t    rgb
);

    // Pick the channel order for the hexcone sector
    always_comb
    begin
        unique case (sector)
            hsv2rgb_pkg::SECTOR_0: rgb = '{r: terms.v, g: terms.t, b: terms.p};
            hsv2rgb_pkg::SECTOR_1: rgb = '{r: terms.q, g: terms.v, b: terms.p};
            hsv2rgb_pkg::SECTOR_2: rgb = '{r: terms.p, g: terms.v, b: terms.t};
            hsv2rgb_pkg::SECTOR_3: rgb = '{r: terms.p, g: terms.q, b: terms.v};
            hsv2rgb_pkg::SECTOR_4: rgb = '{r: terms.t, g: terms.p, b: terms.v};
            default:               rgb = '{r: terms.v, g: terms.p, b: terms.q};
        endcase
    end

endmodule

// File: hdl/hsv_to_rgb_converter.sv
// HSV to RGB converter: five-stage pipeline, one pixel word per clock.
//
// Converts one pixel per clock from hue (1/64 degree, values of 360 degrees
// or more read as 0), saturation and value to 8-bit red, green and blue.
// A new word can be taken on every clock while the output is not stalled:
// each stage has a valid bit and loads whenever it is empty or the stage
// after it moves on, so a stall at the output fills the empty stages before
// it pushes back on the input. The stages are: sector and fraction,
// saturation products, divide by 3840 and p, value products, divide by 255
// with channel routing.
module hsv_to_rgb_converter
(
    input  logic                     clk,
    input  logic                     rst_n,
    hsv2rgb_pix_in_if.sink           pix_in,
    hsv2rgb_pix_out_if.source        pix_out
);

    localparam int unsigned Stages = 5;
    localparam int unsigned CW     = hsv2rgb_pkg::ChanWidth;
    localparam int unsigned FW     = hsv2rgb_pkg::FracWidth;
    localparam int unsigned HW     = hsv2rgb_pkg::HueWidth;

    logic [Stages-1:0] vld_reg;
    logic [Stages-1:0] adv;

    // Advance a stage when it is empty or its successor moves
    always_comb
    begin
        adv[Stages-1] = !vld_reg[Stages-1] || pix_out.ready;
        for (int i = Stages - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign pix_in.ready = adv[0];

    // Valid bits travel with the word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= pix_in.valid;
            end
            for (int i = 1; i < Stages; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // ---------------- Stage 1: clamp hue, find sector and fraction
    logic [HW-1:0]        h_clamped;
    logic [HW-1:0]        sec_offset;
    hsv2rgb_pkg::sector_t sec1_next;
    hsv2rgb_pkg::sector_t sec1_reg;
    logic [FW-1:0]        f1_reg;
    logic [CW-1:0]        s1_reg;
    logic [CW-1:0]        v1_reg;

    always_comb
    begin
        h_clamped = (pix_in.hue >= HW'(hsv2rgb_pkg::HueFullTurn)) ? '0 : pix_in.hue;
        if (h_clamped >= HW'(5 * hsv2rgb_pkg::HueSector))
        begin
            sec1_next  = hsv2rgb_pkg::SECTOR_5;
            sec_offset = HW'(5 * hsv2rgb_pkg::HueSector);
        end
        else if (h_clamped >= HW'(4 * hsv2rgb_pkg::HueSector))
        begin
            sec1_next  = hsv2rgb_pkg::SECTOR_4;
            sec_offset = HW'(4 * hsv2rgb_pkg::HueSector);
        end
        else if (h_clamped >= HW'(3 * hsv2rgb_pkg::HueSector))
        begin
            sec1_next  = hsv2rgb_pkg::SECTOR_3;
            sec_offset = HW'(3 * hsv2rgb_pkg::HueSector);
        end
        else if (h_clamped >= HW'(2 * hsv2rgb_pkg::HueSector))
        begin
            sec1_next  = hsv2rgb_pkg::SECTOR_2;
            sec_offset = HW'(2 * hsv2rgb_pkg::HueSector);
        end
        else if (h_clamped >= HW'(hsv2rgb_pkg::HueSector))
        begin
            sec1_next  = hsv2rgb_pkg::SECTOR_1;
            sec_offset = HW'(hsv2rgb_pkg::HueSector);
        end
        else
        begin
            sec1_next  = hsv2rgb_pkg::SECTOR_0;
            sec_offset = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            sec1_reg <= sec1_next;
            f1_reg   <= FW'(h_clamped - sec_offset);
            s1_reg   <= pix_in.saturation;
            v1_reg   <= pix_in.brightness;
        end
    end

    // ---------------- Stage 2: saturation times fraction and its complement
    hsv2rgb_pkg::sector_t sec2_reg;
    logic [19:0]          sf2_reg;
    logic [19:0]          st2_reg;
    logic [15:0]          pp2_reg;
    logic [CW-1:0]        v2_reg;
    logic [FW-1:0]        f_rest;

    assign f_rest = FW'(hsv2rgb_pkg::HueSector) - f1_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            sec2_reg <= sec1_reg;
            sf2_reg  <= 20'(s1_reg) * 20'(f1_reg);
            st2_reg  <= 20'(s1_reg) * 20'(f_rest);
            pp2_reg  <= 16'(v1_reg) * 16'(CW'(hsv2rgb_pkg::UnitOne) - s1_reg);
            v2_reg   <= v1_reg;
        end
    end

    // ---------------- Stage 3: divide by one sector, form p
    hsv2rgb_pkg::sector_t sec3_reg;
    logic [CW-1:0]        kq3_reg;
    logic [CW-1:0]        kt3_reg;
    logic [CW-1:0]        p3_reg;
    logic [CW-1:0]        v3_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            sec3_reg <= sec2_reg;
            kq3_reg  <= CW'(hsv2rgb_pkg::UnitOne) - hsv2rgb_pkg::div_sector(sf2_reg);
            kt3_reg  <= CW'(hsv2rgb_pkg::UnitOne) - hsv2rgb_pkg::div_sector(st2_reg);
            p3_reg   <= hsv2rgb_pkg::div_unit(pp2_reg);
            v3_reg   <= v2_reg;
        end
    end

    // ---------------- Stage 4: value times the q and t factors
    hsv2rgb_pkg::sector_t sec4_reg;
    logic [15:0]          qp4_reg;
    logic [15:0]          tp4_reg;
    logic [CW-1:0]        p4_reg;
    logic [CW-1:0]        v4_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            sec4_reg <= sec3_reg;
            qp4_reg  <= 16'(v3_reg) * 16'(kq3_reg);
            tp4_reg  <= 16'(v3_reg) * 16'(kt3_reg);
            p4_reg   <= p3_reg;
            v4_reg   <= v3_reg;
        end
    end

    // ---------------- Stage 5: divide by 255, route, hold the output word
    hsv2rgb_pkg::terms_t terms;
    hsv2rgb_pkg::rgb_t   rgb_next;
    hsv2rgb_pkg::rgb_t   rgb_reg;

    always_comb
    begin
        terms.v = v4_reg;
        terms.p = p4_reg;
        terms.q = hsv2rgb_pkg::div_unit(qp4_reg);
        terms.t = hsv2rgb_pkg::div_unit(tp4_reg);
    end

    hsv2rgb_route u_route
    (
        .sector (sec4_reg),
        .terms  (terms),
        .rgb    (rgb_next)
    );

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign pix_out.valid = vld_reg[Stages-1];
    assign pix_out.red   = rgb_reg.r;
    assign pix_out.green = rgb_reg.g;
    assign pix_out.blue  = rgb_reg.b;

    // ---------------- Checks
    // An empty first stage always takes a word
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> pix_in.ready)
        else $error("input stalled with empty first stage");

    // p, q and t never exceed value
    a_terms_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] |-> (terms.p <= terms.v) && (terms.q <= terms.v) && (terms.t <= terms.v))
        else $error("hexcone term above value");

    // A full stage that cannot move keeps its word
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] && !adv[2] |=> vld_reg[2] && $stable(kq3_reg) && $stable(p3_reg))
        else $error("stalled stage lost its word");

endmodule
